// ===== rtl/core/mald_pkg.sv =====
// ----------------------------------------------------------------------------
// mald_pkg
// Shared types and constants for the moving-average loudness detector.
// ----------------------------------------------------------------------------
package mald_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CFG_ADDR_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_LEVEL     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOUD_THRESHOLD = 2'd1;

  // Register values after reset
  localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RST     = 12'd2048;
  localparam logic [SAMPLE_W-1:0] LOUD_THRESHOLD_RST = 12'd1000;

  // Queue depths: between front and back, and on the result side
  localparam int unsigned MID_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 8;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t average_level;
    logic    loud;
    logic    loud_event;
  } result_t;

endpackage

// ===== rtl/core/mald_ram.sv =====
// ----------------------------------------------------------------------------
// mald_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mald_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mald_fifo.sv =====
// ----------------------------------------------------------------------------
// mald_fifo
// Small flip-flop queue with occupancy count.
// ----------------------------------------------------------------------------
module mald_fifo #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign count    = count_r;

endmodule

// ===== rtl/core/mald_front.sv =====
// ----------------------------------------------------------------------------
// mald_front
// Configuration registers and deviation stage: forms |sample - zero level|.
// ----------------------------------------------------------------------------
module mald_front
  import mald_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SAMPLE_W-1:0]   cfg_wdata,
  input  logic                  in_push,
  input  sample_t               in_sample,
  input  logic                  mid_full,
  output logic                  mid_push,
  output sample_t               mid_dev,
  output sample_t               loud_threshold
);

  sample_t zero_level_r, zero_level_nxt;
  sample_t threshold_r, threshold_nxt;

  always_comb begin
    zero_level_nxt = zero_level_r;
    threshold_nxt  = threshold_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ZERO_LEVEL:     zero_level_nxt = cfg_wdata;
        REG_LOUD_THRESHOLD: threshold_nxt  = cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_level_r <= ZERO_LEVEL_RST;
      threshold_r  <= LOUD_THRESHOLD_RST;
    end else begin
      zero_level_r <= zero_level_nxt;
      threshold_r  <= threshold_nxt;
    end
  end

  assign mid_push       = in_push & ~mid_full;
  assign mid_dev        = (in_sample >= zero_level_r) ? (in_sample - zero_level_r)
                                                      : (zero_level_r - in_sample);
  assign loud_threshold = threshold_r;

endmodule

// ===== rtl/core/mald_back.sv =====
// ----------------------------------------------------------------------------
// mald_back
// Ring store, running total, divide by the window and threshold compare.
// ----------------------------------------------------------------------------
module mald_back
  import mald_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  sample_t              mid_dev,
  output logic                 mid_pop,
  input  sample_t              loud_threshold,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_push,
  output result_t              res_data
);

  localparam int unsigned SLOT_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W   = $clog2(WINDOW * 4095 + 1);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned M_W     = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + M_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  sample_t           s1_dev_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_old_ok_r;
  sample_t           ring_rdata, old_dev;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              reported_r;
  logic [OUT_CNT_W+1:0] committed;
  sample_t           avg;
  logic              loud;

  // Take an item only when the result queue has room for everything in flight
  assign committed = (OUT_CNT_W+2)'(out_count) + (OUT_CNT_W+2)'(s1_vld_r)
                   + (OUT_CNT_W+2)'(s2_vld_r) + (OUT_CNT_W+2)'(s3_vld_r);
  assign mid_pop   = ~mid_empty && (committed < (OUT_CNT_W+2)'(OUT_DEPTH));

  always_comb begin
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    if (mid_pop) begin
      if (slot_r == SLOT_W'(WINDOW - 1)) begin
        slot_nxt    = '0;
        wrapped_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  mald_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_slot_r),
    .wdata (s1_dev_r),
    .re    (mid_pop),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  // Entries not yet written since reset count as zero
  assign old_dev   = s1_old_ok_r ? ring_rdata : '0;
  assign total_nxt = total_r - SUM_W'(old_dev) + SUM_W'(s1_dev_r);

  assign avg  = prod_r[SHIFT +: SAMPLE_W];
  assign loud = (avg > loud_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      wrapped_r  <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      total_r    <= '0;
      reported_r <= 1'b0;
    end else begin
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      s1_vld_r  <= mid_pop;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      if (s1_vld_r) begin
        total_r <= total_nxt;
      end
      if (s3_vld_r) begin
        reported_r <= loud;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_dev_r    <= mid_dev;
      s1_slot_r   <= slot_r;
      s1_old_ok_r <= wrapped_r;
    end
    if (s2_vld_r) begin
      prod_r <= PROD_W'(total_r) * PROD_W'(RECIP);
    end
  end

  assign res_push                = s3_vld_r;
  assign res_data.average_level  = avg;
  assign res_data.loud           = loud;
  assign res_data.loud_event     = loud & ~reported_r;

endmodule

// ===== rtl/core/moving_average_loudness_detector.sv =====
// ----------------------------------------------------------------------------
// moving_average_loudness_detector
// Mean absolute deviation of ADC samples over a sliding window, compared
// against a threshold, with a one-shot event on each quiet-to-loud change.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_push / in_full    | in_sample
//   result   | out_pop / out_empty  | out_average_level, out_loud, out_loud_event
//   config   | cfg_we               | cfg_addr, cfg_wdata
//
// One sample per cycle sustained while the result side keeps up. A result
// passes from its sample transfer through the front queue, ring read,
// running total update and reciprocal multiply into the result queue,
// then shows on the result ports.
// Reset is synchronous; no clearing pass is needed: a wrap flag marks ring
// slots not yet written since reset, which read as zero.
// A stalled result side fills the 8-entry result queue, then the 2-entry
// front queue, then raises in_full; each side stalls on its own.
// ----------------------------------------------------------------------------
module moving_average_loudness_detector
  import mald_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SAMPLE_W-1:0]   cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic [SAMPLE_W-1:0]   out_average_level,
  output logic                  out_loud,
  output logic                  out_loud_event
);

  logic                 mid_push, mid_pop, mid_full, mid_empty;
  sample_t              mid_dev_in, mid_dev_out;
  sample_t              loud_threshold;
  logic                 res_push;
  result_t              res_data, res_head;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 res_full;

  // Front: hold config, form the deviation, advance into the queue
  mald_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_sample      (in_sample),
    .mid_full       (mid_full),
    .mid_push       (mid_push),
    .mid_dev        (mid_dev_in),
    .loud_threshold (loud_threshold)
  );

  // Short queue that decouples front from back
  mald_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_dev_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_dev_out),
    .empty     (mid_empty),
    .count     ()
  );

  assign in_full = mid_full;

  // Back: ring, running total, average and threshold
  mald_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .mid_empty      (mid_empty),
    .mid_dev        (mid_dev_out),
    .mid_pop        (mid_pop),
    .loud_threshold (loud_threshold),
    .out_count      (out_count),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  // Result queue; back only issues work that is sure to fit here
  mald_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty),
    .count     (out_count)
  );

  assign out_average_level = res_head.average_level;
  assign out_loud          = res_head.loud & ~res_full | res_head.loud;
  assign out_loud_event    = res_head.loud_event;

endmodule

// ===== rtl/core/mald_checker.sv =====
// ----------------------------------------------------------------------------
// mald_checker
// Port-level checks for the loudness detector, bound to the top level.
// ----------------------------------------------------------------------------
module mald_checker
  import mald_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_ADDR_W-1:0] cfg_addr,
  input logic [SAMPLE_W-1:0]   cfg_wdata,
  input logic                  in_push,
  input logic                  in_full,
  input logic [SAMPLE_W-1:0]   in_sample,
  input logic                  out_pop,
  input logic                  out_empty,
  input logic [SAMPLE_W-1:0]   out_average_level,
  input logic                  out_loud,
  input logic                  out_loud_event
);

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // An event is only reported on a loud result
  a_event_loud: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (!out_loud_event || out_loud))
    else $error("loud_event without loud");

  // A loud result is never followed directly by an event
  a_no_double_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_loud) |=> (out_empty || !out_loud_event))
    else $error("event right after a loud result");

  // A waiting result holds until its transfer
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_average_level) && $stable(out_loud)
       && $stable(out_loud_event)))
    else $error("result changed while stalled");

endmodule

bind moving_average_loudness_detector mald_checker u_mald_checker (.*);

// ===== sim/moving_average_loudness_detector_test.sv =====
// ----------------------------------------------------------------------------
// moving_average_loudness_detector_test
// Self-checking bench for the sliding-window loudness detector. A local
// predictor tracks the deviation ring, the running total and the one-shot
// state. Every sample transfer queues one predicted result, and every result
// transfer is compared field by field with the oldest prediction. Both
// handshakes idle at random, and the register settings step through their
// extremes between phases.
// ----------------------------------------------------------------------------
module moving_average_loudness_detector_test;
  import mald_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW        = 64;
  localparam int unsigned SLOT_W        = $clog2(WINDOW);
  localparam int unsigned TOTAL_W       = SAMPLE_W + SLOT_W;
  localparam int unsigned SETTLE_CYCLES = 8;       // idle wait after draining, before register writes
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned PHASE_ITEMS   = 185;

  // Indexes that decode to no register; writes there must leave state alone
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int unsigned {
    BURST_QUIET,
    BURST_LOUD,
    BURST_NOISE
  } burst_kind_e;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [SAMPLE_W-1:0]   cfg_wdata = '0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_pop   = 1'b0;
  logic                  out_empty;
  logic [SAMPLE_W-1:0]   out_average_level;
  logic                  out_loud;
  logic                  out_loud_event;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  moving_average_loudness_detector #(
    .WINDOW (WINDOW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_sample         (in_sample),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_average_level (out_average_level),
    .out_loud          (out_loud),
    .out_loud_event    (out_loud_event)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the ring, total, one-shot flag and regs
  // --------------------------------------------------------------------------
  sample_t            dev_ring [WINDOW];
  logic [SLOT_W-1:0]  ring_wr;
  logic [TOTAL_W-1:0] win_sum;
  logic               loud_seen;
  sample_t            zero_lvl;
  sample_t            loud_thr;

  result_t            level_queue [$];   // predicted results, oldest first
  result_t            oldest_level;

  int unsigned fail_count   = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned loud_events  = 0;
  int unsigned cycle_count  = 0;

  // Idle control: a steady side never pauses between transfers
  bit          in_steady  = 1'b0;
  bit          out_steady = 1'b0;
  int unsigned pop_gap;
  int unsigned pop_hold   = 0;

  function automatic void clear_predictor();
    foreach (dev_ring[i]) dev_ring[i] = '0;
    ring_wr   = '0;
    win_sum   = '0;
    loud_seen = 1'b0;
    zero_lvl  = ZERO_LEVEL_RST;
    loud_thr  = LOUD_THRESHOLD_RST;
  endfunction

  // Advance the window by one sample and queue the result it must produce
  function automatic void predict_loudness(input sample_t s);
    sample_t dev;
    result_t r;
    dev = (s >= zero_lvl) ? sample_t'(s - zero_lvl) : sample_t'(zero_lvl - s);
    // The total always covers the entry being replaced, so no underflow here
    win_sum          = win_sum - TOTAL_W'(dev_ring[ring_wr]) + TOTAL_W'(dev);
    dev_ring[ring_wr] = dev;
    ring_wr          = ring_wr + 1'b1;   // wraps at the window size
    r.average_level  = sample_t'(win_sum / WINDOW);
    r.loud           = (r.average_level > loud_thr);
    r.loud_event     = r.loud && !loud_seen;
    loud_seen        = r.loud;
    if (r.loud_event) loud_events++;
    level_queue.push_back(r);
  endfunction

  function automatic int unsigned idle_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop with random pauses, check every transfer in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop  <= 1'b0;
      pop_hold <= 0;
    end else if (out_pop && !out_empty) begin
      results_seen++;
      if (level_queue.size() == 0) begin
        $error("result transfer with nothing expected: average_level %0d",
               out_average_level);
        fail_count++;
      end else begin
        oldest_level = level_queue.pop_front();
        if (out_average_level !== oldest_level.average_level) begin
          $error("average_level: expected %0d, actual %0d",
                 oldest_level.average_level, out_average_level);
          fail_count++;
        end
        if (out_loud !== oldest_level.loud) begin
          $error("loud: expected %0b, actual %0b", oldest_level.loud, out_loud);
          fail_count++;
        end
        if (out_loud_event !== oldest_level.loud_event) begin
          $error("loud_event: expected %0b, actual %0b",
                 oldest_level.loud_event, out_loud_event);
          fail_count++;
        end
      end
      // Draw the pause before the next pop; zero keeps pop high
      pop_gap = idle_gap(out_steady);
      out_pop  <= (pop_gap == 0);
      pop_hold <= pop_gap;
    end else if (!out_pop) begin
      if (pop_hold > 1) pop_hold <= pop_hold - 1;
      else out_pop <= 1'b1;
    end
  end

  // Watchdog: end the run if the block stops moving
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, level_queue.size());
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Transfer one sample, after a random pause, and predict its result
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = idle_gap(in_steady);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= s;
    // Hold the sample until an edge sees push high with full low
    do @(posedge clk); while (in_full);
    predict_loudness(s);
    samples_sent++;
  endtask

  // Drop push and hold until every predicted result has been popped
  task automatic drain_results();
    in_push <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk);
  endtask

  // Write one register with the block idle, then mirror it in the predictor
  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                input logic [SAMPLE_W-1:0]   val);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ZERO_LEVEL:     zero_lvl = val;
      REG_LOUD_THRESHOLD: loud_thr = val;
      default: ;  // no register here, the block must ignore it
    endcase
    reg_writes++;
  endtask

  // Shape one sample for a burst: quiet hugs the zero level, loud swings rail
  // to rail, noise covers the whole code range
  function automatic sample_t burst_sample(input burst_kind_e kind,
                                           input int unsigned  spread);
    int v;
    case (kind)
      BURST_QUIET: begin
        v = int'(zero_lvl) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      BURST_LOUD: begin
        v = $urandom_range(0, 1) ? int'($urandom_range(0, 400))
                                 : int'($urandom_range(3695, 4095));
      end
      default: v = $urandom_range(0, 4095);
    endcase
    return sample_t'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Warm-up on reset register values: missing window entries count as zero
  task automatic test_warmup_defaults();
    sample_t warm [10] = '{12'd2048, 12'd2047, 12'd2049, 12'd0, 12'd4095,
                           12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd2048};
    foreach (warm[i]) send_sample(warm[i]);
  endtask

  // Register extremes, full-scale deviation, ignored indexes, dead threshold
  task automatic test_register_extremes();
    write_register(REG_ZERO_LEVEL, 12'd0);
    write_register(REG_LOUD_THRESHOLD, 12'd0);
    send_sample(12'd0);
    send_sample(12'd4095);   // largest deviation; the window is already loud, so no event
    send_sample(12'd4095);
    send_sample(12'd0);
    write_register(REG_SPARE_A, 12'hFFF);
    write_register(REG_SPARE_B, 12'h000);
    send_sample(12'd4095);
    write_register(REG_ZERO_LEVEL, 12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    // A threshold at full scale can never be exceeded
    write_register(REG_LOUD_THRESHOLD, 12'd4095);
    send_sample(12'd0);
    send_sample(12'd0);
    write_register(REG_LOUD_THRESHOLD, 12'd2048);
    send_sample(12'd0);
    send_sample(12'd2048);
  endtask

  // Phases of bursts under stepped settings, with idling drawn per burst
  task automatic test_random_phases();
    sample_t     zl;
    sample_t     th;
    int unsigned phase_start;
    int unsigned burst_len;
    int unsigned spread;
    burst_kind_e kind;
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          zl = ZERO_LEVEL_RST;
          th = LOUD_THRESHOLD_RST;
        end
        1: begin
          zl = 12'd0;
          th = 12'd2048;
        end
        2: begin
          zl = 12'd4095;
          th = 12'd0;
        end
        3: begin
          zl = sample_t'($urandom_range(0, 4095));
          th = 12'd4095;
        end
        default: begin
          zl = sample_t'($urandom_range(0, 4095));
          th = sample_t'($urandom_range(0, 2048));
        end
      endcase
      write_register(REG_ZERO_LEVEL, zl);
      write_register(REG_LOUD_THRESHOLD, th);
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: kind = BURST_QUIET;
          4, 5, 6, 7: kind = BURST_LOUD;
          default:    kind = BURST_NOISE;
        endcase
        // Long bursts can sweep the whole window; short ones break the pattern
        burst_len  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8)
                                               : $urandom_range(16, 100);
        // Trim the last burst so the phase ends on its item count
        if (burst_len > PHASE_ITEMS - (samples_sent - phase_start)) begin
          burst_len = PHASE_ITEMS - (samples_sent - phase_start);
        end
        spread     = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
        repeat (burst_len) send_sample(burst_sample(kind, spread));
        // Now and then hold the sender until the result side catches up
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_predictor();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_warmup_defaults();
    test_register_extremes();
    test_random_phases();

    // Hold until the last result is in, then watch for anything extra
    drain_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d results across %0d register writes",
             samples_sent, results_seen, reg_writes);
    $display("Zero level and threshold swept to both rails; %0d loud events predicted",
             loud_events);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
